// ----- hw/rtl/two_phase_envelope_generator_macros.svh -----
// Assertion macros for the two-phase envelope generator.
`ifndef TWO_PHASE_ENVELOPE_GENERATOR_MACROS_SVH
`define TWO_PHASE_ENVELOPE_GENERATOR_MACROS_SVH

// Property checked on every clock edge outside reset.
`define TPEG_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define TPEG_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/tpeg_pkg.sv -----
// Shared types and constants for the two-phase envelope generator.
package tpeg_pkg;

   localparam int unsigned CSR_IDX_W = 3;

   // action codes
   localparam logic [1:0] ACT_TICK    = 2'd0;
   localparam logic [1:0] ACT_KEY_ON  = 2'd1;
   localparam logic [1:0] ACT_RELEASE = 2'd2;

   // phase codes
   localparam logic [1:0] PH_IDLE    = 2'd0;
   localparam logic [1:0] PH_ATTACK  = 2'd1;
   localparam logic [1:0] PH_DECAY   = 2'd2;
   localparam logic [1:0] PH_RELEASE = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ATTACK_STEP    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ATTACK_LENGTH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_STEP     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_LENGTH   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_STEP   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_LENGTH = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_RDROP     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_START_DDROP    = 3'd7;

   localparam logic [6:0] ATTEN_MAX   = 7'h7F;
   localparam logic [7:0] AUDIBLE_MIN = 8'h88;
   localparam logic [7:0] LEVEL_MAX   = 8'hFF;
   localparam logic [7:0] STEP_MASK   = 8'hFE;
   localparam logic [7:0] HI_NIB_MASK = 8'hF0;
   localparam logic [7:0] LO_NIB_MASK = 8'h0F;

   typedef struct packed {
      logic [1:0] action;
      logic [6:0] attenuation;
      logic [7:0] fade_level;
   } req_type;

   typedef struct packed {
      logic [7:0] voice_level;
      logic       audible;
      logic [7:0] env_value;
      logic [1:0] phase_now;
   } rsp_type;

   // envelope after the current request
   typedef struct packed {
      logic [7:0] level;
      logic [1:0] phase;
   } env_type;

endpackage

// ----- hw/rtl/tpeg_core.sv -----
// Envelope state registers, patch registers and per-request state update.
module tpeg_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [tpeg_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                    csr_data,
   input  logic                          fire,
   input  logic [1:0]                    action,
   output tpeg_pkg::env_type             env_next
);
   import tpeg_pkg::*;

   logic [7:0] attack_step_ff, attack_length_ff, decay_step_ff, decay_length_ff;
   logic [7:0] release_step_ff, release_length_ff, rate_rdrop_ff, start_ddrop_ff;

   logic [7:0] level_ff, level_in;
   logic [1:0] phase_ff, phase_in;
   logic [7:0] step_amount_ff, step_amount_in;
   logic [7:0] steps_left_ff, steps_left_in;
   logic [7:0] wait_count_ff, wait_count_in;

   function automatic logic [7:0] sat_sub(input logic [7:0] a, input logic [7:0] b);
      return (a >= b) ? 8'(a - b) : 8'd0;
   endfunction

   function automatic logic [7:0] apply_step(input logic [7:0] lv, input logic [7:0] st);
      logic [8:0] sum;
      sum = {1'b0, lv} + {1'b0, st};
      if (st[0]) return sat_sub(lv, st & STEP_MASK);
      return sum[8] ? LEVEL_MAX : sum[7:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         attack_step_ff    <= '0;
         attack_length_ff  <= '0;
         decay_step_ff     <= '0;
         decay_length_ff   <= '0;
         release_step_ff   <= '0;
         release_length_ff <= '0;
         rate_rdrop_ff     <= '0;
         start_ddrop_ff    <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ATTACK_STEP:    attack_step_ff    <= csr_data;
            CSR_ATTACK_LENGTH:  attack_length_ff  <= csr_data;
            CSR_DECAY_STEP:     decay_step_ff     <= csr_data;
            CSR_DECAY_LENGTH:   decay_length_ff   <= csr_data;
            CSR_RELEASE_STEP:   release_step_ff   <= csr_data;
            CSR_RELEASE_LENGTH: release_length_ff <= csr_data;
            CSR_RATE_RDROP:     rate_rdrop_ff     <= csr_data;
            CSR_START_DDROP:    start_ddrop_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [7:0] wait_dec;
      logic [7:0] steps_dec;
      logic [7:0] stepped;
      wait_dec  = 8'(wait_count_ff - 8'd1);
      steps_dec = 8'(steps_left_ff - 8'd1);
      stepped   = apply_step(level_ff, step_amount_ff);

      level_in       = level_ff;
      phase_in       = phase_ff;
      step_amount_in = step_amount_ff;
      steps_left_in  = steps_left_ff;
      wait_count_in  = wait_count_ff;

      unique case (action)
         ACT_TICK: begin
            wait_count_in = wait_dec;
            if (wait_dec == 8'd0) begin
               wait_count_in = rate_rdrop_ff & LO_NIB_MASK;
               if (phase_ff != PH_IDLE) begin
                  level_in      = stepped;
                  steps_left_in = steps_dec;
                  if (steps_dec == 8'd0) begin
                     if (phase_ff == PH_ATTACK) begin
                        phase_in       = PH_DECAY;
                        steps_left_in  = decay_length_ff;
                        step_amount_in = decay_step_ff;
                        level_in       = sat_sub(stepped, start_ddrop_ff & HI_NIB_MASK);
                     end else begin
                        phase_in = PH_IDLE;
                     end
                  end
               end
            end
         end
         ACT_KEY_ON: begin
            level_in       = {start_ddrop_ff[3:0], 4'd0};
            phase_in       = PH_ATTACK;
            steps_left_in  = attack_length_ff;
            step_amount_in = attack_step_ff;
            wait_count_in  = 8'd1;
         end
         ACT_RELEASE: begin
            level_in       = sat_sub(level_ff, rate_rdrop_ff & HI_NIB_MASK);
            phase_in       = PH_RELEASE;
            steps_left_in  = release_length_ff;
            step_amount_in = release_step_ff;
         end
         default: ;  // unused action leaves the state alone
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff       <= '0;
         phase_ff       <= PH_IDLE;
         step_amount_ff <= '0;
         steps_left_ff  <= '0;
         wait_count_ff  <= '0;
      end else if (fire) begin
         level_ff       <= level_in;
         phase_ff       <= phase_in;
         step_amount_ff <= step_amount_in;
         steps_left_ff  <= steps_left_in;
         wait_count_ff  <= wait_count_in;
      end
   end

   assign env_next.level = level_in;
   assign env_next.phase = phase_in;

endmodule

// ----- hw/rtl/tpeg_level.sv -----
// Output level: envelope high nibble times volume from attenuation plus fade.
module tpeg_level (
   input  tpeg_pkg::env_type env,
   input  logic [6:0]        attenuation,
   input  logic [7:0]        fade_level,
   output tpeg_pkg::rsp_type rsp
);
   import tpeg_pkg::*;

   logic [8:0] atten_sum;
   logic [6:0] atten_sat;
   logic [3:0] volume;
   logic [7:0] product;

   always_comb begin
      atten_sum = {2'b00, attenuation} + {1'b0, fade_level};
      atten_sat = (atten_sum > {2'b00, ATTEN_MAX}) ? ATTEN_MAX : atten_sum[6:0];
      volume    = ~atten_sat[6:3];
      product   = {4'd0, env.level[7:4]} * {4'd0, volume};

      rsp.voice_level = product;
      rsp.audible     = (product >= AUDIBLE_MIN);
      rsp.env_value   = env.level;
      rsp.phase_now   = env.phase;
   end

endmodule

// ----- hw/rtl/two_phase_envelope_generator.sv -----
// Top level of the two-phase envelope generator: request and result registers.
// One voice envelope (attack, decay, release). Every request (tick, key-on,
// release) yields exactly one result carrying the updated envelope level,
// phase and output level. The block takes one request per clock cycle while
// no result is stalled; the request register feeds a single state-update
// pass into the result register. A stalled result holds the result register
// and then the request register; the request side stalls only when both are
// full. Patch registers are written through the csr_ port; the user must do so
// only while no request is pending, as the block does not enforce this.
`include "two_phase_envelope_generator_macros.svh"

module two_phase_envelope_generator (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  tpeg_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output tpeg_pkg::rsp_type              rsp_data,
   input  logic                           csr_wr_en,
   input  logic [tpeg_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                     csr_data
);
   import tpeg_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic    out_free;
   logic    fire;
   logic    req_accept;
   env_type env_next;
   logic    audible_want;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign fire       = in_valid_ff && out_free;
   assign req_stall  = in_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   tpeg_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .fire      (fire),
      .action    (in_data_ff.action),
      .env_next  (env_next)
   );

   tpeg_level u_level (
      .env         (env_next),
      .attenuation (in_data_ff.attenuation),
      .fade_level  (in_data_ff.fade_level),
      .rsp         (rsp_data_in)
   );

   always_comb begin
      in_valid_in  = req_accept ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
      rsp_valid_in = fire ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) in_data_ff <= req_data;
      if (fire)       rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign audible_want = (rsp_data.voice_level >= AUDIBLE_MIN);

   `TPEG_ASSERT(a_stall_needs_request, !req_stall || in_valid_ff, "stall without request")
   `TPEG_ASSERT_NEXT(a_request_moves, in_valid_ff && !rsp_valid_ff, rsp_valid, "request lost")
   `TPEG_ASSERT(a_level_range, !rsp_valid || (rsp_data.voice_level <= 8'd225), "level range")
   `TPEG_ASSERT(a_audible_match, !rsp_valid || (rsp_data.audible == audible_want), "audible flag")

endmodule

// ----- tb/two_phase_envelope_generator_tb.sv -----
// Self-checking testbench for the two-phase envelope generator.
module two_phase_envelope_generator_tb;
   import tpeg_pkg::*;

   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int         CYCLE_LIMIT = 400000;
   localparam int         HOLD_OFF_CYCLES = 120;
   localparam int         HOLD_OFF_AFTER = 100;

   // Envelope predictor plus the queue of results still owed by the block.
   class envelope_scoreboard;
      logic [7:0] patch [8];
      logic [7:0] level;
      logic [1:0] phase;
      logic [7:0] step_amount;
      logic [7:0] steps_left;
      logic [7:0] wait_count;
      rsp_type    owed_results [$];
      int         errors;

      function new();
         foreach (patch[i]) patch[i] = 8'h00;
         level       = 8'h00;
         phase       = PH_IDLE;
         step_amount = 8'h00;
         steps_left  = 8'h00;
         wait_count  = 8'h00;
         errors      = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [7:0] value);
         patch[idx] = value;
      endfunction

      function int pending();
         return owed_results.size();
      endfunction

      function logic [7:0] floor_sub(logic [7:0] a, logic [7:0] b);
         return (a >= b) ? a - b : 8'h00;
      endfunction

      // bit 0 picks subtract (floor 0) or add (ceiling LEVEL_MAX)
      function logic [7:0] take_step(logic [7:0] lv, logic [7:0] amount);
         logic [8:0] sum;
         if (amount[0])
            return floor_sub(lv, amount & STEP_MASK);
         sum = {1'b0, lv} + {1'b0, amount};
         return (sum > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : sum[7:0];
      endfunction

      function void advance_tick();
         logic [7:0] lv;
         wait_count = wait_count - 8'd1;
         if (wait_count != 8'd0)
            return;
         wait_count = patch[CSR_RATE_RDROP] & LO_NIB_MASK;
         if (phase == PH_IDLE)
            return;
         lv = take_step(level, step_amount);
         steps_left = steps_left - 8'd1;
         if (steps_left == 8'd0) begin
            if (phase == PH_ATTACK) begin
               phase       = PH_DECAY;
               steps_left  = patch[CSR_DECAY_LENGTH];
               step_amount = patch[CSR_DECAY_STEP];
               lv          = floor_sub(lv, patch[CSR_START_DDROP] & HI_NIB_MASK);
            end else begin
               phase = PH_IDLE;
            end
         end
         level = lv;
      endfunction

      function void predict_request(req_type r);
         logic [8:0] atten_sum;
         logic [3:0] volume;
         logic [7:0] out_lv;
         rsp_type    owed;
         case (r.action)
            ACT_TICK: advance_tick();
            ACT_KEY_ON: begin
               level       = {patch[CSR_START_DDROP][3:0], 4'h0};
               phase       = PH_ATTACK;
               steps_left  = patch[CSR_ATTACK_LENGTH];
               step_amount = patch[CSR_ATTACK_STEP];
               wait_count  = 8'd1;
            end
            ACT_RELEASE: begin
               level       = floor_sub(level, patch[CSR_RATE_RDROP] & HI_NIB_MASK);
               phase       = PH_RELEASE;
               steps_left  = patch[CSR_RELEASE_LENGTH];
               step_amount = patch[CSR_RELEASE_STEP];
            end
            default: ;
         endcase
         atten_sum = {2'b00, r.attenuation} + {1'b0, r.fade_level};
         if (atten_sum > {2'b00, ATTEN_MAX})
            atten_sum = {2'b00, ATTEN_MAX};
         volume           = 4'hF - atten_sum[6:3];
         out_lv           = {4'h0, level[7:4]} * {4'h0, volume};
         owed.voice_level = out_lv;
         owed.audible     = (out_lv >= AUDIBLE_MIN);
         owed.env_value   = level;
         owed.phase_now   = phase;
         owed_results.push_back(owed);
      endfunction

      task report(string msg);
         $display("ERROR: %s", msg);
         errors++;
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (owed_results.size() == 0) begin
            report("result with no request outstanding");
            return;
         end
         want = owed_results.pop_front();
         if (got.voice_level !== want.voice_level)
            report($sformatf("voice_level %0d, predicted %0d", got.voice_level,
                             want.voice_level));
         if (got.audible !== want.audible)
            report($sformatf("audible %0b, predicted %0b", got.audible, want.audible));
         if (got.env_value !== want.env_value)
            report($sformatf("env_value %0h, predicted %0h", got.env_value, want.env_value));
         if (got.phase_now !== want.phase_now)
            report($sformatf("phase_now %0d, predicted %0d", got.phase_now, want.phase_now));
      endtask
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_stall;
   rsp_type              rsp_data;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [7:0]           csr_data;

   envelope_scoreboard env_check = new();
   int                 requests_in;
   int                 cycles;
   int                 no_gap_left;
   bit                 held_off;

   two_phase_envelope_generator u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // handshake monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            env_check.predict_request(req_data);
            requests_in++;
         end
         if (rsp_valid && !rsp_stall)
            env_check.check_result(rsp_data);
      end
   end

   // result side: random stalls, one long hold-off to back up the block
   initial begin
      int roll;
      int run_len;
      @(negedge clock);
      forever begin
         @(negedge clock);
         if (!reset && !held_off && requests_in >= HOLD_OFF_AFTER) begin
            held_off = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end else begin
            roll = $urandom_range(99);
            if (roll < 55) begin
               rsp_stall <= 1'b0;
               run_len = $urandom_range(1, 12);
            end else if (roll < 85) begin
               rsp_stall <= 1'b1;
               run_len = $urandom_range(1, 3);
            end else if (roll < 97) begin
               rsp_stall <= 1'b0;
               run_len = 50;
            end else begin
               rsp_stall <= 1'b1;
               run_len = $urandom_range(10, 40);
            end
            repeat (run_len - 1) @(negedge clock);
         end
      end
   end

   function int pick_gap();
      int roll;
      if (no_gap_left > 0) begin
         no_gap_left--;
         return 0;
      end
      roll = $urandom_range(99);
      if (roll < 5) begin
         no_gap_left = 40;
         return 0;
      end
      if (roll < 60) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function req_type make_req(logic [1:0] action, logic [6:0] atten, logic [7:0] fade);
      req_type r;
      r.action      = action;
      r.attenuation = atten;
      r.fade_level  = fade;
      return r;
   endfunction

   function req_type random_req(int keyon_pct, int release_pct, int unused_pct);
      int         roll;
      logic [1:0] action;
      roll = $urandom_range(99);
      if (roll < keyon_pct)
         action = ACT_KEY_ON;
      else if (roll < keyon_pct + release_pct)
         action = ACT_RELEASE;
      else if (roll < keyon_pct + release_pct + unused_pct)
         action = ACT_UNUSED;
      else
         action = ACT_TICK;
      // half the time keep the sum low so the volume is not zero
      if ($urandom_range(1))
         return make_req(action, 7'($urandom), 8'($urandom));
      return make_req(action, 7'($urandom_range(0, 40)), 8'($urandom_range(0, 40)));
   endfunction

   task send_request(req_type r);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task write_csr(logic [CSR_IDX_W-1:0] idx, logic [7:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      env_check.write_reg(idx, value);
   endtask

   task write_patch(logic [7:0] a_step, logic [7:0] a_len, logic [7:0] d_step,
                    logic [7:0] d_len, logic [7:0] r_step, logic [7:0] r_len,
                    logic [7:0] rate_rdrop, logic [7:0] start_ddrop);
      write_csr(CSR_ATTACK_STEP, a_step);
      write_csr(CSR_ATTACK_LENGTH, a_len);
      write_csr(CSR_DECAY_STEP, d_step);
      write_csr(CSR_DECAY_LENGTH, d_len);
      write_csr(CSR_RELEASE_STEP, r_step);
      write_csr(CSR_RELEASE_LENGTH, r_len);
      write_csr(CSR_RATE_RDROP, rate_rdrop);
      write_csr(CSR_START_DDROP, start_ddrop);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // stop offering and wait until every owed result has come back
   task settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (env_check.pending() != 0) @(posedge clock);
   endtask

   task run_phase(int count, int keyon_pct, int release_pct, int unused_pct);
      send_request(random_req(100, 0, 0));
      repeat (count - 1) send_request(random_req(keyon_pct, release_pct, unused_pct));
      settle();
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      rsp_stall   = 1'b0;
      csr_wr_en   = 1'b0;
      csr_index   = '0;
      csr_data    = 8'h00;
      requests_in = 0;
      cycles      = 0;
      no_gap_left = 0;
      held_off    = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: one step per tick, short phases, start level 0xC0
      write_patch(8'h40, 8'd2, 8'h21, 8'd2, 8'h11, 8'd1, 8'h31, 8'h2C);
      send_request(make_req(ACT_TICK, 7'h00, 8'h00));     // idle tick
      send_request(make_req(ACT_UNUSED, 7'h7F, 8'hFF));
      send_request(make_req(ACT_KEY_ON, 7'h00, 8'h00));
      send_request(make_req(ACT_TICK, 7'h00, 8'h00));     // add saturates high
      send_request(make_req(ACT_TICK, 7'h00, 8'h00));     // attack into decay
      send_request(make_req(ACT_TICK, 7'h7F, 8'h00));
      send_request(make_req(ACT_TICK, 7'h00, 8'hFF));     // decay into idle
      send_request(make_req(ACT_TICK, 7'h55, 8'h2A));
      send_request(make_req(ACT_KEY_ON, 7'h00, 8'h7F));
      send_request(make_req(ACT_RELEASE, 7'h2A, 8'h55));
      send_request(make_req(ACT_TICK, 7'h10, 8'h01));     // release into idle
      send_request(make_req(ACT_RELEASE, 7'h00, 8'h00));  // release from idle
      send_request(make_req(ACT_RELEASE, 7'h00, 8'h00));
      send_request(make_req(ACT_RELEASE, 7'h00, 8'h00));  // drop floors at 0
      send_request(make_req(ACT_TICK, 7'h00, 8'h00));     // subtract floors at 0
      send_request(make_req(ACT_KEY_ON, 7'h00, 8'h00));
      send_request(make_req(ACT_TICK, 7'h7F, 8'hFF));
      send_request(make_req(ACT_UNUSED, 7'h01, 8'hFE));
      send_request(make_req(ACT_TICK, 7'h40, 8'h3F));     // sum exactly at limit
      send_request(make_req(ACT_TICK, 7'h40, 8'h40));     // sum over limit
      send_request(make_req(ACT_KEY_ON, 7'h00, 8'hAA));
      send_request(make_req(ACT_TICK, 7'h08, 8'h00));
      settle();

      // extremes: zero wait and zero lengths wrap to 256
      write_patch(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      run_phase(60, 10, 10, 4);
      write_patch(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      run_phase(80, 10, 10, 4);

      // full 256-step attack, then decay
      write_patch(8'h02, 8'h00, 8'h05, 8'h03, 8'h11, 8'h00, 8'hA1, 8'h7F);
      run_phase(300, 0, 0, 1);

      repeat (5) begin
         write_patch(8'($urandom), 8'($urandom_range(1, 6)), 8'($urandom),
                     8'($urandom_range(1, 6)), 8'($urandom), 8'($urandom_range(1, 4)),
                     {4'($urandom), 4'($urandom_range(1, 3))}, 8'($urandom));
         run_phase(72, 8, 8, 4);
      end

      repeat (10) @(posedge clock);
      if (env_check.errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ----- two_phase_envelope_generator.f -----
+incdir+hw/rtl
hw/rtl/tpeg_pkg.sv
hw/rtl/tpeg_core.sv
hw/rtl/tpeg_level.sv
hw/rtl/two_phase_envelope_generator.sv
tb/two_phase_envelope_generator_tb.sv
